// ----- design/pointer_intern_table_assert.svh -----
// Assertion macros used by the value interning table sequencer.
`ifndef POINTER_INTERN_TABLE_ASSERT_SVH
`define POINTER_INTERN_TABLE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PIT_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Check a consequence in the same cycle as its antecedent.
`define PIT_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define PIT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pit_pkg.sv -----
// Shared constants and types of the value interning table.
`timescale 1ns / 1ps

package pit_pkg;

    localparam int VALUE_W      = 64;
    localparam int SLOT_FIELD_W = 10;
    localparam int ACTION_W     = 2;
    localparam int SLOT_COUNT_DEFAULT = 1024;

    // Input beat layout: value_in, then slot_in, padded to whole bytes.
    localparam int IN_DATA_W  = ((VALUE_W + SLOT_FIELD_W + 7) / 8) * 8;
    // Result beat layout: slot_out, then value_out, padded to whole bytes.
    localparam int OUT_DATA_W = ((SLOT_FIELD_W + VALUE_W + 7) / 8) * 8;

    localparam logic [ACTION_W-1:0] ACT_INTERN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RESOLVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd2;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic [VALUE_W-1:0]      value;
    } pit_result_t;

endpackage

// ----- design/pointer_intern_table.sv -----
// Top level of the value interning table: sequencer, slot memory, result register.
`timescale 1ns / 1ps

// Value interning table. Each input beat carries a request in s_tuser: intern
// (0) maps a 64-bit value to a slot number, resolve (1) returns the value held
// in a slot, clear (2) empties the table and returns no beat; code 3 is
// dropped. Slot 0 stands for the value zero; new values take slots 1, 2, ...
// in order, and an intern of a new value with the table full answers slot 0.
// A resolve of slot 0 or of an unfilled slot answers value 0. One request
// is in work at a time and s_tready is low meanwhile. An intern of a nonzero
// value walks the filled slots through a single comparator fed by the slot
// memory's one read port, one entry per cycle, and stops at the first match.
// A finished result waits in the output register, and the next request is
// taken while it waits. Clear only resets the fill count, so no memory
// clearing pass is needed after reset.
module pointer_intern_table #(
    parameter int SLOT_COUNT = pit_pkg::SLOT_COUNT_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [63:0] value_in, [73:64] slot_in, [79:74] zero
    input  logic [pit_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [pit_pkg::ACTION_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [9:0] slot_out, [73:10] value_out, [79:74] zero
    output logic [pit_pkg::OUT_DATA_W-1:0]   m_tdata
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SF = pit_pkg::SLOT_FIELD_W;
    localparam int VW = pit_pkg::VALUE_W;

    logic                   res_valid;
    logic                   res_ready;
    pit_pkg::pit_result_t   res;
    logic                   mem_rd_en;
    logic [SW-1:0]          mem_rd_addr;
    logic [VW-1:0]          mem_rd_data;
    logic                   mem_wr_en;
    logic [SW-1:0]          mem_wr_addr;
    logic [VW-1:0]          mem_wr_data;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [pit_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    pit_ctrl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tuser),
        .in_value    (s_tdata[VW-1:0]),
        .in_slot     (s_tdata[VW+SF-1:VW]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    pit_store #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (res_valid && res_ready) begin
            m_tdata_reg <= pit_pkg::OUT_DATA_W'({res.value, res.slot});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/pit_store.sv -----
// Slot value memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pit_store #(
    parameter int SLOT_COUNT = pit_pkg::SLOT_COUNT_DEFAULT,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [SW-1:0]               wr_addr,
    input  logic [pit_pkg::VALUE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [SW-1:0]               rd_addr,
    output logic [pit_pkg::VALUE_W-1:0] rd_data
);

    logic [pit_pkg::VALUE_W-1:0] mem [SLOT_COUNT];
    logic [pit_pkg::VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/pit_ctrl.sv -----
// Sequencer and shared comparator: scan, append, resolve and clear.
`timescale 1ns / 1ps

module pit_ctrl #(
    parameter int SLOT_COUNT = pit_pkg::SLOT_COUNT_DEFAULT,
    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int CW = $clog2(SLOT_COUNT + 1)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pit_pkg::ACTION_W-1:0]     in_action,
    input  logic [pit_pkg::VALUE_W-1:0]      in_value,
    input  logic [pit_pkg::SLOT_FIELD_W-1:0] in_slot,
    output logic                             res_valid,
    input  logic                             res_ready,
    output pit_pkg::pit_result_t             res,
    output logic                             mem_rd_en,
    output logic [SW-1:0]                    mem_rd_addr,
    input  logic [pit_pkg::VALUE_W-1:0]      mem_rd_data,
    output logic                             mem_wr_en,
    output logic [SW-1:0]                    mem_wr_addr,
    output logic [pit_pkg::VALUE_W-1:0]      mem_wr_data
);

`include "pointer_intern_table_assert.svh"

    // Width wide enough for both a slot field and a fill count.
    localparam int XW = (CW > pit_pkg::SLOT_FIELD_W) ? CW : pit_pkg::SLOT_FIELD_W;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_RESOLVE = 4'b0100,
        ST_FINISH  = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic [CW-1:0]               issue_reg, issue_next;
    logic [CW-1:0]               chk_reg, chk_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic [pit_pkg::VALUE_W-1:0] value_reg, value_next;
    pit_pkg::pit_result_t        res_reg, res_next;
    logic [XW-1:0]               slot_x;
    logic [XW-1:0]               fill_x;
    logic                        hit;

    assign slot_x = XW'(in_slot);
    assign fill_x = XW'(fill_reg);
    // The one comparator, reused for every stored entry of a scan.
    assign hit    = chk_valid_reg && (mem_rd_data == value_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_FINISH);
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        issue_next     = issue_reg;
        chk_next       = chk_reg;
        chk_valid_next = 1'b0;
        value_next     = value_reg;
        res_next       = res_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = issue_reg[SW-1:0];
        mem_wr_en      = 1'b0;
        mem_wr_addr    = fill_reg[SW-1:0];
        mem_wr_data    = value_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_action)
                        pit_pkg::ACT_INTERN: begin
                            res_next.value = '0;
                            if (in_value == '0) begin
                                res_next.slot = '0;
                                state_next    = ST_FINISH;
                            end else if (fill_reg == CW'(1)) begin
                                // Empty table: append at once.
                                mem_wr_en     = 1'b1;
                                mem_wr_data   = in_value;
                                res_next.slot = pit_pkg::SLOT_FIELD_W'(fill_reg);
                                fill_next     = fill_reg + 1'b1;
                                state_next    = ST_FINISH;
                            end else begin
                                value_next = in_value;
                                issue_next = CW'(1);
                                state_next = ST_SCAN;
                            end
                        end
                        pit_pkg::ACT_RESOLVE: begin
                            res_next.slot = '0;
                            if (slot_x == '0 || slot_x >= fill_x) begin
                                res_next.value = '0;
                                state_next     = ST_FINISH;
                            end else begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = slot_x[SW-1:0];
                                state_next  = ST_RESOLVE;
                            end
                        end
                        pit_pkg::ACT_CLEAR: begin
                            fill_next = CW'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    res_next.slot = pit_pkg::SLOT_FIELD_W'(chk_reg);
                    state_next    = ST_FINISH;
                end else if (issue_reg < fill_reg) begin
                    // Read the next filled entry while comparing the last.
                    mem_rd_en      = 1'b1;
                    chk_next       = issue_reg;
                    chk_valid_next = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                end else if (fill_reg == CW'(SLOT_COUNT)) begin
                    // No match and no room left: report failure.
                    res_next.slot = '0;
                    state_next    = ST_FINISH;
                end else begin
                    mem_wr_en     = 1'b1;
                    res_next.slot = pit_pkg::SLOT_FIELD_W'(fill_reg);
                    fill_next     = fill_reg + 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_RESOLVE: begin
                res_next.value = mem_rd_data;
                state_next     = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= CW'(1);
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            chk_valid_reg <= chk_valid_next;
        end
        issue_reg <= issue_next;
        chk_reg   <= chk_next;
        value_reg <= value_next;
        res_reg   <= res_next;
    end

    `PIT_ASSERT_ALWAYS(a_fill_range, aclk, aresetn, fill_reg != '0 && fill_reg <= CW'(SLOT_COUNT), "fill count out of range")
    `PIT_ASSERT_IMPLY(a_scan_filled, aclk, aresetn, chk_valid_reg, chk_reg != '0 && chk_reg < fill_reg, "scan compares an unfilled slot")
    `PIT_ASSERT_NEXT(a_append_grows, aclk, aresetn, mem_wr_en, fill_reg == CW'($past(fill_reg) + 1'b1), "append did not advance fill count")
    `PIT_ASSERT_NEXT(a_res_hold, aclk, aresetn, res_valid && !res_ready, res_valid && $stable(res_reg), "pending result changed")

endmodule
